// File: src/srh_pkg.sv
// Types, codes and constants for the serial rumble handshake responder.
package srh_pkg;

   typedef enum logic [2:0] {
      STAGE_HANDSHAKE = 3'd0,
      STAGE_MAGIC1    = 3'd1,
      STAGE_MAGIC2    = 3'd2,
      STAGE_RUMBLE    = 3'd3,
      STAGE_FINALIZE  = 3'd4
   } stage_type;

   localparam int unsigned WORD_W  = 32;
   localparam int unsigned HALF_W  = 16;
   localparam int unsigned INDEX_W = 3;

   localparam logic [HALF_W-1:0]  EXIT_LOW    = 16'h8002;
   localparam logic [HALF_W-1:0]  KEY_DONE    = 16'h8000;
   localparam logic [WORD_W-1:0]  MAGIC_A     = 32'h1000_0010;
   localparam logic [WORD_W-1:0]  MAGIC_B     = 32'h2000_0013;
   localparam logic [WORD_W-1:0]  RUMBLE_POLL = 32'h3000_0003;
   localparam logic [WORD_W-1:0]  REPLY_OFF   = 32'h4000_0004;
   localparam logic [WORD_W-1:0]  REPLY_ON    = 32'h4000_0026;

   // number of key halfwords; match_index saturates here
   localparam logic [INDEX_W-1:0] KEY_COUNT   = 3'd4;

   // unlock key, character pairs low byte first
   function automatic logic [HALF_W-1:0] key_half(input logic [1:0] idx);
      logic [HALF_W-1:0] half;
      case (idx)
         2'd0:    half = 16'h494E;
         2'd1:    half = 16'h544E;
         2'd2:    half = 16'h4E45;
         default: half = 16'h4F44;
      endcase
      return half;
   endfunction

endpackage

// File: src/serial_rumble_handshake.sv
// Serial rumble handshake responder: at most one response word per received word.
//
//  channel | ports                                   | direction
//  --------+-----------------------------------------+----------
//  request | req_valid req_ready req_rx_word          | in
//          | req_rumble_on                           |
//  result  | rsp_valid rsp_ready rsp_tx_word          | out
//
// One request per cycle while req_ready is high; its response sits in the
// output register in the cycle after acceptance. The single stage-update step
// sets the rate. A request in finalize produces no response and clears all state.
// req_ready stays high while the output register is empty or being drained,
// so a stalled response only holds back the next request.
// Synchronous reset returns to the handshake stage with all state but the response word cleared.
module serial_rumble_handshake (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [srh_pkg::WORD_W-1:0]    req_rx_word,
   input  logic                          req_rumble_on,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [srh_pkg::WORD_W-1:0]    rsp_tx_word
);

   srh_pkg::stage_type                 stage_ff, stage_in;
   logic [srh_pkg::INDEX_W-1:0]        match_index_ff, match_index_in;
   logic [srh_pkg::HALF_W-1:0]         upper_half_ff, upper_half_in;
   logic [srh_pkg::HALF_W-1:0]         lower_half_ff, lower_half_in;
   logic                               rsp_valid_ff, rsp_valid_in;
   logic [srh_pkg::WORD_W-1:0]         rsp_tx_word_ff, rsp_tx_word_in;

   logic                               req_accept;
   logic                               emit;
   logic [srh_pkg::WORD_W-1:0]         result;

   // handshake-stage helpers
   logic [srh_pkg::HALF_W-1:0]         rx_low;
   logic [srh_pkg::HALF_W-1:0]         rx_high;
   logic                               is_exit;
   logic [srh_pkg::INDEX_W-1:0]        idx_start;
   logic [srh_pkg::INDEX_W-1:0]        idx_next;
   logic [srh_pkg::HALF_W-1:0]         hs_upper;
   logic [srh_pkg::HALF_W-1:0]         hs_lower;

   assign req_ready  = !rsp_valid_ff || rsp_ready;
   assign req_accept = req_valid && req_ready;

   always_comb begin
      rx_low    = req_rx_word[srh_pkg::HALF_W-1:0];
      rx_high   = req_rx_word[srh_pkg::WORD_W-1:srh_pkg::HALF_W];
      is_exit   = (rx_low == srh_pkg::EXIT_LOW);
      // partner out of step restarts the key
      idx_start = (rx_high != lower_half_ff) ? '0 : match_index_ff;
      idx_next  = idx_start;
      if (idx_start < srh_pkg::KEY_COUNT &&
          req_rx_word == ~{upper_half_ff, lower_half_ff}) begin
         idx_next = idx_start + 3'd1;
      end
      hs_upper = (idx_next >= srh_pkg::KEY_COUNT) ? srh_pkg::KEY_DONE
                                                  : srh_pkg::key_half(idx_next[1:0]);
      hs_lower = ~rx_low;
   end

   // next state
   always_comb begin
      stage_in       = stage_ff;
      match_index_in = match_index_ff;
      upper_half_in  = upper_half_ff;
      lower_half_in  = lower_half_ff;
      if (req_accept) begin
         unique case (stage_ff)
            srh_pkg::STAGE_HANDSHAKE: begin
               if (is_exit) begin
                  stage_in = srh_pkg::STAGE_MAGIC1;
               end else begin
                  match_index_in = idx_next;
                  upper_half_in  = hs_upper;
                  lower_half_in  = hs_lower;
               end
            end
            srh_pkg::STAGE_MAGIC1: begin
               stage_in = (req_rx_word == srh_pkg::MAGIC_A) ? srh_pkg::STAGE_MAGIC2
                                                            : srh_pkg::STAGE_FINALIZE;
            end
            srh_pkg::STAGE_MAGIC2: begin
               stage_in = (req_rx_word == srh_pkg::MAGIC_B) ? srh_pkg::STAGE_RUMBLE
                                                            : srh_pkg::STAGE_FINALIZE;
            end
            srh_pkg::STAGE_RUMBLE: begin
               if (req_rx_word != srh_pkg::RUMBLE_POLL) begin
                  stage_in = srh_pkg::STAGE_FINALIZE;
               end
            end
            default: begin
               // finalize and unused codes
               stage_in       = srh_pkg::STAGE_HANDSHAKE;
               match_index_in = '0;
               upper_half_in  = '0;
               lower_half_in  = '0;
            end
         endcase
      end
   end

   // outputs
   always_comb begin
      emit   = 1'b1;
      result = '0;
      unique case (stage_ff)
         srh_pkg::STAGE_HANDSHAKE: begin
            result = is_exit ? srh_pkg::MAGIC_A : {hs_upper, hs_lower};
         end
         srh_pkg::STAGE_MAGIC1: begin
            if (req_rx_word == srh_pkg::MAGIC_A) begin
               result = srh_pkg::MAGIC_B;
            end
         end
         srh_pkg::STAGE_MAGIC2: begin
            if (req_rx_word == srh_pkg::MAGIC_B) begin
               result = srh_pkg::REPLY_OFF;
            end
         end
         srh_pkg::STAGE_RUMBLE: begin
            if (req_rx_word == srh_pkg::RUMBLE_POLL) begin
               result = req_rumble_on ? srh_pkg::REPLY_ON : srh_pkg::REPLY_OFF;
            end
         end
         default: begin
            emit = 1'b0;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in   = rsp_valid_ff;
      rsp_tx_word_in = rsp_tx_word_ff;
      if (req_accept) begin
         rsp_valid_in = emit;
         if (emit) begin
            rsp_tx_word_in = result;
         end
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff       <= srh_pkg::STAGE_HANDSHAKE;
         match_index_ff <= '0;
         upper_half_ff  <= '0;
         lower_half_ff  <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         stage_ff       <= stage_in;
         match_index_ff <= match_index_in;
         upper_half_ff  <= upper_half_in;
         lower_half_ff  <= lower_half_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_tx_word_ff <= rsp_tx_word_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_tx_word = rsp_tx_word_ff;

   // key position never runs past the end of the key
   assert property (@(posedge clock) disable iff (reset)
      match_index_ff <= srh_pkg::KEY_COUNT)
      else $error("match index beyond key length");

   // a request in finalize leaves everything cleared and sends nothing
   assert property (@(posedge clock) disable iff (reset)
      req_accept && stage_ff == srh_pkg::STAGE_FINALIZE |=>
         stage_ff == srh_pkg::STAGE_HANDSHAKE && match_index_ff == '0 &&
         upper_half_ff == '0 && lower_half_ff == '0 && !rsp_valid_ff)
      else $error("finalize did not clear state");

   // a rumble poll is answered with one of the two motor replies
   assert property (@(posedge clock) disable iff (reset)
      req_accept && stage_ff == srh_pkg::STAGE_RUMBLE &&
      req_rx_word == srh_pkg::RUMBLE_POLL |=>
         rsp_valid_ff && (rsp_tx_word_ff == srh_pkg::REPLY_ON ||
                          rsp_tx_word_ff == srh_pkg::REPLY_OFF))
      else $error("rumble poll not answered");

   // handshake halves only move in handshake or finalize
   assert property (@(posedge clock) disable iff (reset)
      stage_ff == srh_pkg::STAGE_MAGIC1 || stage_ff == srh_pkg::STAGE_MAGIC2 ||
      stage_ff == srh_pkg::STAGE_RUMBLE |=>
         $stable(upper_half_ff) && $stable(lower_half_ff))
      else $error("handshake halves changed after handshake");

endmodule

// File: tb/sv/srh_response_check.sv
// Response predictor and scoreboard for the serial rumble handshake responder.
module srh_response_check (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   input  logic                       req_ready,
   input  logic [srh_pkg::WORD_W-1:0] req_rx_word,
   input  logic                       req_rumble_on,
   input  logic                       rsp_valid,
   input  logic                       rsp_ready,
   input  logic [srh_pkg::WORD_W-1:0] rsp_tx_word,
   output int                         errors,
   output int                         awaiting
);
   import srh_pkg::*;

   // key halfwords, first at the low end
   localparam logic [3:0][HALF_W-1:0] UNLOCK_KEY = {16'h4F44, 16'h4E45, 16'h544E, 16'h494E};

   stage_type          stage;
   logic [INDEX_W-1:0] key_pos;
   logic [HALF_W-1:0]  high_half;
   logic [HALF_W-1:0]  low_half;
   logic [WORD_W-1:0]  tx_expected[$];

   initial begin
      errors = 0;
      awaiting = 0;
   end

   function automatic void clear_link();
      stage = STAGE_HANDSHAKE;
      key_pos = '0;
      high_half = '0;
      low_half = '0;
   endfunction

   // steps the link by one request; returns 1 when a response word is due
   function automatic logic respond(input logic [WORD_W-1:0] rx, input logic motor,
                                    output logic [WORD_W-1:0] tx);
      tx = '0;
      case (stage)
         STAGE_HANDSHAKE: begin
            if (rx[HALF_W-1:0] == EXIT_LOW) begin
               stage = STAGE_MAGIC1;
               tx = MAGIC_A;
            end else begin
               // partner lost step: key starts over
               if (rx[WORD_W-1:HALF_W] != low_half) key_pos = '0;
               if (key_pos >= KEY_COUNT) begin
                  high_half = KEY_DONE;
               end else begin
                  if (rx == ~{high_half, low_half}) key_pos = key_pos + 3'd1;
                  high_half = (key_pos >= KEY_COUNT) ? KEY_DONE : UNLOCK_KEY[key_pos[1:0]];
               end
               low_half = ~rx[HALF_W-1:0];
               tx = {high_half, low_half};
            end
         end
         STAGE_MAGIC1: begin
            if (rx == MAGIC_A) begin
               tx = MAGIC_B;
               stage = STAGE_MAGIC2;
            end else begin
               stage = STAGE_FINALIZE;
            end
         end
         STAGE_MAGIC2: begin
            if (rx == MAGIC_B) begin
               tx = REPLY_OFF;
               stage = STAGE_RUMBLE;
            end else begin
               stage = STAGE_FINALIZE;
            end
         end
         STAGE_RUMBLE: begin
            if (rx == RUMBLE_POLL) tx = motor ? REPLY_ON : REPLY_OFF;
            else stage = STAGE_FINALIZE;
         end
         default: begin
            clear_link();
            return 1'b0;
         end
      endcase
      return 1'b1;
   endfunction

   always @(posedge clock) begin : watch
      logic [WORD_W-1:0] tx;
      logic [WORD_W-1:0] want;
      if (reset) begin
         clear_link();
         tx_expected.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (tx_expected.size() == 0) begin
               errors++;
               $display("%0t: tx_word expected none, got %h", $time, rsp_tx_word);
            end else begin
               want = tx_expected.pop_front();
               if (rsp_tx_word !== want) begin
                  errors++;
                  $display("%0t: tx_word expected %h, got %h", $time, want, rsp_tx_word);
               end
            end
         end
         if (req_valid && req_ready) begin
            if (respond(req_rx_word, req_rumble_on, tx)) tx_expected.push_back(tx);
         end
      end
      awaiting <= tx_expected.size();
   end

endmodule

// File: tb/sv/tb_serial_rumble_handshake.sv
// Stimulus and verdict for the serial rumble handshake responder.
module tb_serial_rumble_handshake;
   import srh_pkg::*;

   localparam int ITEM_TARGET = 1400;
   localparam int CALM_TAIL   = 150;
   localparam int LONG_HOLD   = 200;

   logic              clock = 1'b0;
   logic              reset;
   logic              req_valid;
   logic              req_ready;
   logic [WORD_W-1:0] req_rx_word;
   logic              req_rumble_on;
   logic              rsp_valid;
   logic              rsp_ready;
   logic [WORD_W-1:0] rsp_tx_word;
   int                mismatches;
   int                awaiting;

   logic [WORD_W-1:0] rx_words[$];
   logic              motor_reqs[$];
   int                sent = 0;
   bit                calm = 1'b0;

   always #2 clock = ~clock;

   serial_rumble_handshake dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_rx_word   (req_rx_word),
      .req_rumble_on (req_rumble_on),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_tx_word   (rsp_tx_word)
   );

   srh_response_check check (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_rx_word   (req_rx_word),
      .req_rumble_on (req_rumble_on),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_tx_word   (rsp_tx_word),
      .errors        (mismatches),
      .awaiting      (awaiting)
   );

   task automatic queue_word(input logic [WORD_W-1:0] rx, input logic motor);
      rx_words.push_back(rx);
      motor_reqs.push_back(motor);
   endtask

   function automatic logic [WORD_W-1:0] noise_word();
      logic [WORD_W-1:0] w;
      do w = $urandom; while (w[HALF_W-1:0] == EXIT_LOW);
      return w;
   endfunction

   // from a cleared link: each key step needs a word that keeps step and
   // loads the key halfword low, then its exact inverse
   task automatic queue_key_walk(input int steps, output logic [HALF_W-1:0] low);
      logic [HALF_W-1:0] k;
      low = '0;
      for (int s = 0; s < steps; s++) begin
         k = key_half(2'(s));
         queue_word({low, k}, 1'($urandom_range(0, 1)));
         queue_word({~k, k}, 1'($urandom_range(0, 1)));
         low = ~k;
      end
   endtask

   task automatic queue_directed();
      logic [HALF_W-1:0] low;
      // extremes in handshake, then straight through every stage
      queue_word(32'hFFFF_FFFF, 1'b1);
      queue_word(32'h0000_0000, 1'b0);
      queue_word({16'hFFFF, EXIT_LOW}, 1'b0);
      queue_word(MAGIC_A, 1'b1);
      queue_word(MAGIC_B, 1'b0);
      queue_word(RUMBLE_POLL, 1'b1);
      queue_word(RUMBLE_POLL, 1'b0);
      queue_word(32'hFFFF_FFFF, 1'b1);
      queue_word(32'h0000_0000, 1'b0);
      // whole key, stay on the exhausted key, then lose step
      queue_key_walk(4, low);
      queue_word({low, 16'h1234}, 1'b0);
      queue_word({~low, 16'h0000}, 1'b1);
      queue_word({16'h0000, EXIT_LOW}, 1'b1);
      queue_word(MAGIC_B, 1'b0);
      queue_word(32'hFFFF_8002, 1'b1);
      // wrong second magic
      queue_word({16'h5A5A, EXIT_LOW}, 1'b0);
      queue_word(MAGIC_A, 1'b1);
      queue_word(MAGIC_A, 1'b0);
      queue_word(32'h0000_0000, 1'b1);
   endtask

   task automatic queue_session();
      logic [HALF_W-1:0] low;
      logic [WORD_W-1:0] w;
      queue_key_walk(($urandom_range(0, 3) == 0) ? $urandom_range(0, 3) : 4, low);
      w = noise_word();
      if ($urandom_range(0, 1)) queue_word({low, w[HALF_W-1:0]}, 1'($urandom_range(0, 1)));
      repeat (($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0)
         queue_word(noise_word(), 1'($urandom_range(0, 1)));
      w = $urandom;
      queue_word({w[WORD_W-1:HALF_W], EXIT_LOW}, 1'($urandom_range(0, 1)));
      if ($urandom_range(0, 9) == 0) begin
         queue_word(noise_word(), 1'($urandom_range(0, 1)));
      end else begin
         queue_word(MAGIC_A, 1'($urandom_range(0, 1)));
         if ($urandom_range(0, 9) == 0) begin
            queue_word(noise_word(), 1'($urandom_range(0, 1)));
         end else begin
            queue_word(MAGIC_B, 1'($urandom_range(0, 1)));
            repeat ($urandom_range(0, 8)) queue_word(RUMBLE_POLL, 1'($urandom_range(0, 1)));
            case ($urandom_range(0, 2))
               0: queue_word(noise_word(), 1'($urandom_range(0, 1)));
               1: queue_word(RUMBLE_POLL ^ (32'h1 << $urandom_range(0, 31)),
                             1'($urandom_range(0, 1)));
               default: queue_word(MAGIC_B, 1'($urandom_range(0, 1)));
            endcase
         end
      end
      // finalize: any word clears the link
      queue_word($urandom, 1'($urandom_range(0, 1)));
   endtask

   initial begin : limit
      #2_000_000;
      $display("** serial_rumble_handshake: FAILED **");
      $finish;
   end

   initial begin : requests
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_rx_word <= '0;
      req_rumble_on <= 1'b0;
      queue_directed();
      while (rx_words.size() < ITEM_TARGET) queue_session();
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      foreach (rx_words[i]) begin
         calm = (i >= rx_words.size() - CALM_TAIL);
         if (!calm && $urandom_range(0, 5) == 0) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clock);
         end
         req_valid <= 1'b1;
         req_rx_word <= rx_words[i];
         req_rumble_on <= motor_reqs[i];
         do @(posedge clock); while (!req_ready);
         sent++;
      end
      req_valid <= 1'b0;
      for (int n = 0; n < 1000 && awaiting != 0; n++) @(posedge clock);
      repeat (8) @(posedge clock);
      if (mismatches == 0 && awaiting == 0) begin
         $display("** serial_rumble_handshake: PASSED **");
      end else begin
         $display("** serial_rumble_handshake: FAILED **");
      end
      $finish;
   end

   initial begin : responses
      bit held;
      held = 1'b0;
      rsp_ready <= 1'b0;
      do @(posedge clock); while (reset);
      rsp_ready <= 1'b1;
      forever begin
         @(posedge clock);
         if (!held && sent >= 400) begin
            // long back-pressure while requests keep coming
            held = 1'b1;
            rsp_ready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
            rsp_ready <= 1'b1;
         end else if (!calm && $urandom_range(0, 7) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clock);
            rsp_ready <= 1'b1;
         end
      end
   end

endmodule
